// ===== sv/nbg_pkg.sv =====
// Shared types and constants for the Netpbm body to gray converter.
// Used by nbg_ctrl, nbg_dp and netpbm_body_to_gray_top; no dependencies.
package nbg_pkg;

   // Q16 BT.601 luma weights, sum 65536
   localparam logic [15:0] W_RED   = 16'd19595;
   localparam logic [15:0] W_GREEN = 16'd38470;
   localparam logic [15:0] W_BLUE  = 16'd7471;

   localparam int SAMPLE_W = 16;
   localparam int NUM_W    = 25;   // scaled numerator, below 2^25
   localparam int QUOT_W   = 8;
   localparam int STEP_W   = 3;

   // colour channel codes
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   // register indexes
   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_MAX_VALUE  = 1'd0;
   localparam csr_index_type CSR_COLOR_MODE = 1'd1;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_PREP = 6'b000010,
      ST_NUM  = 6'b000100,
      ST_SAT  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_EMIT = 6'b100000
   } state_type;

   typedef struct packed {
      logic take;        // input beat accepted
      logic prep;        // weight/accumulate or form gray numerator
      logic load_luma;   // form colour numerator from the accumulator
      logic sat_check;   // compare against 256 * max
      logic div_step;    // one restoring quotient step
      logic emit;        // load the output register
   } cmd_type;

   typedef struct packed {
      logic sample_ready;  // accepted beat completes a sample
      logic pixel_ready;   // captured sample completes a pixel
      logic luma_path;     // colour mode
      logic saturate;      // quotient would exceed 255
      logic div_last;      // final quotient step
      logic out_free;      // output register can take a result
   } stat_type;

   function automatic logic [15:0] luma_weight(input logic [1:0] ch);
      logic [15:0] w;
      case (ch)
         CH_RED:   w = W_RED;
         CH_GREEN: w = W_GREEN;
         default:  w = W_BLUE;
      endcase
      return w;
   endfunction

endpackage

// ===== sv/netpbm_body_to_gray_top.sv =====
// Netpbm body to gray converter: takes P5/P6 body bytes one beat at a time
// (two bytes per sample, high first, when max_value exceeds 255) and returns
// one 8-bit gray value per pixel, round(sample*255/max) for gray images and
// round(luma*255/max) with Q16 BT.601 weights for colour images, clamped to
// 255. A byte that completes no pixel is taken while idle, and a colour red or
// green sample then passes the prep state to accumulate; a completed pixel
// passes prep, the numerator state in colour mode, the saturation check, the
// 8-step restoring divider and emit, skipping the divider when the value
// saturates, and emit waits for the output register. The output register lets
// a finished beat wait while the next byte is taken. frame_start restarts byte
// and channel phase. Depends on nbg_pkg, nbg_ctrl and nbg_dp.
module netpbm_body_to_gray_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  nbg_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_write_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_frame_start,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_gray_pixel
);
   import nbg_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   nbg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   nbg_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_data_byte    (req_data_byte),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_gray_pixel   (rsp_gray_pixel),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

// ===== sv/nbg_ctrl.sv =====
// Controller state machine of the Netpbm body to gray converter.
// Depends on nbg_pkg; drives the command struct of nbg_dp.
module nbg_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  nbg_pkg::stat_type stat,
   output nbg_pkg::cmd_type  cmd
);
   import nbg_pkg::*;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.take      = req_valid && (state_ff == ST_IDLE);
      cmd.prep      = (state_ff == ST_PREP);
      cmd.load_luma = (state_ff == ST_NUM);
      cmd.sat_check = (state_ff == ST_SAT);
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.emit      = (state_ff == ST_EMIT) && stat.out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.take && stat.sample_ready) state_in = ST_PREP;
         end
         ST_PREP: begin
            if (!stat.pixel_ready) state_in = ST_IDLE;
            else if (stat.luma_path) state_in = ST_NUM;
            else state_in = ST_SAT;
         end
         ST_NUM: state_in = ST_SAT;
         ST_SAT: begin
            state_in = stat.saturate ? ST_EMIT : ST_DIV;
         end
         ST_DIV: begin
            if (stat.div_last) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && !stat.div_last |=> state_ff == ST_DIV)
      else $error("divider left before its last step");

   a_half_sample: assert property (@(posedge clock) disable iff (reset)
      cmd.take && !stat.sample_ready |=> state_ff == ST_IDLE)
      else $error("high byte started a computation");

   a_partial_pixel: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PREP) && !stat.pixel_ready |=> state_ff == ST_IDLE && !req_stall)
      else $error("partial colour pixel did not return to idle");

endmodule

// ===== sv/nbg_dp.sv =====
// Datapath of the Netpbm body to gray converter: registers, sample assembly,
// luma accumulation, saturating restoring divider and output register.
// Depends on nbg_pkg; commanded by nbg_ctrl.
module nbg_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  nbg_pkg::csr_index_type csr_index,
   input  logic [15:0]           csr_write_data,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_frame_start,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_gray_pixel,
   input  nbg_pkg::cmd_type      cmd,
   output nbg_pkg::stat_type     stat
);
   import nbg_pkg::*;

   logic [15:0]          max_value_ff, max_value_in;
   logic                 color_mode_ff, color_mode_in;
   logic [7:0]           high_byte_ff, high_byte_in;
   logic                 byte_phase_ff, byte_phase_in;
   logic [1:0]           channel_ff, channel_in;
   logic [31:0]          acc_ff, acc_in;
   logic [SAMPLE_W-1:0]  sample_ff, sample_in;
   logic [1:0]           ch_cap_ff, ch_cap_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [QUOT_W-1:0]    quot_ff, quot_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [7:0]           rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [15:0]          eff_max;
   logic                 wide;
   logic                 phase_now;
   logic [1:0]           ch_now;
   logic [SAMPLE_W-1:0]  sample_now;
   logic [31:0]          prod;
   logic [31:0]          acc_base;
   logic [40:0]          luma_scaled;
   logic [NUM_W-1:0]     gray_scaled;
   logic [NUM_W-1:0]     sat_limit;
   logic [NUM_W-1:0]     trial;
   logic                 fits;

   assign eff_max   = (max_value_ff == 16'd0) ? 16'd1 : max_value_ff;
   assign wide      = |eff_max[15:8];
   assign phase_now = req_frame_start ? 1'b0 : byte_phase_ff;
   assign ch_now    = req_frame_start ? CH_RED : channel_ff;
   assign sample_now = wide ? {high_byte_ff, req_data_byte} : {8'd0, req_data_byte};

   assign prod     = 32'(luma_weight(ch_cap_ff)) * 32'(sample_ff);
   assign acc_base = (ch_cap_ff == CH_RED) ? 32'd0 : acc_ff;

   // colour: (acc*255 + max*2^15) >> 16, divided by max afterwards
   assign luma_scaled = {1'b0, acc_ff, 8'd0} - {9'd0, acc_ff} + {10'd0, eff_max, 15'd0};
   // gray: sample*255 + floor(max/2), divided by max afterwards
   assign gray_scaled = {1'b0, sample_ff, 8'd0} - {9'd0, sample_ff}
                        + {10'd0, eff_max[15:1]};

   assign sat_limit = {1'b0, eff_max, 8'd0};
   assign trial     = {9'd0, eff_max} << step_ff;
   assign fits      = (num_ff >= trial);

   assign stat.sample_ready = !(wide && !phase_now);
   assign stat.pixel_ready  = !color_mode_ff || ((ch_cap_ff != CH_RED) && (ch_cap_ff != CH_GREEN));
   assign stat.luma_path    = color_mode_ff;
   assign stat.saturate     = (num_ff >= sat_limit);
   assign stat.div_last     = (step_ff == '0);
   assign stat.out_free     = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gray_pixel = rsp_data_ff;

   always_comb begin
      max_value_in  = max_value_ff;
      color_mode_in = color_mode_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_VALUE:  max_value_in  = csr_write_data;
            CSR_COLOR_MODE: color_mode_in = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      high_byte_in  = high_byte_ff;
      byte_phase_in = byte_phase_ff;
      channel_in    = channel_ff;
      sample_in     = sample_ff;
      ch_cap_in     = ch_cap_ff;
      if (cmd.take) begin
         if (wide && !phase_now) begin
            // hold the high byte and wait for the low one
            high_byte_in  = req_data_byte;
            byte_phase_in = 1'b1;
            channel_in    = ch_now;
         end else begin
            byte_phase_in = 1'b0;
            sample_in     = sample_now;
            ch_cap_in     = ch_now;
            if (!color_mode_ff) channel_in = CH_RED;
            else if (ch_now == CH_RED) channel_in = CH_GREEN;
            else if (ch_now == CH_GREEN) channel_in = CH_BLUE;
            else channel_in = CH_RED;
         end
      end
   end

   always_comb begin
      acc_in  = acc_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      if (cmd.prep) begin
         if (color_mode_ff) acc_in = acc_base + prod;
         else num_in = gray_scaled;
      end
      if (cmd.load_luma) num_in = luma_scaled[40:16];
      if (cmd.sat_check) begin
         quot_in = stat.saturate ? '1 : '0;
         step_in = '1;
      end
      if (cmd.div_step) begin
         if (fits) num_in = num_ff - trial;
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_data_in  = quot_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_value_ff  <= 16'd255;
         color_mode_ff <= 1'b0;
         high_byte_ff  <= 8'd0;
         byte_phase_ff <= 1'b0;
         channel_ff    <= CH_RED;
         acc_ff        <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         max_value_ff  <= max_value_in;
         color_mode_ff <= color_mode_in;
         high_byte_ff  <= high_byte_in;
         byte_phase_ff <= byte_phase_in;
         channel_ff    <= channel_in;
         acc_ff        <= acc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      ch_cap_ff   <= ch_cap_in;
      num_ff      <= num_in;
      quot_ff     <= quot_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      cmd.sat_check && !stat.saturate |=> step_ff == '1 && quot_ff == '0)
      else $error("divider not primed after saturation check");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff && rsp_data_ff == $past(quot_ff))
      else $error("result not loaded into output register");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("stalled result beat changed");

endmodule
